@@ hw/rtl/hsvc_pkg.sv @@
// ----------------------------------------------------------------------------
// hsvc_pkg
// Shared constants, types and the reciprocal constants used by the HSV to
// RGB565 pixel pipeline.
// ----------------------------------------------------------------------------
package hsvc_pkg;

  // Field widths
  localparam int HueW   = 10;
  localparam int LevelW = 8;
  localparam int PixW   = 16;

  // Reduced hue (0..359), sector offset (0..59)
  localparam int HmodW  = 9;
  localparam int OffW   = 6;

  // Level and sector geometry
  localparam int LevelMax   = 255;
  localparam int SectorSpan = 60;
  localparam int FullCircle = 360;
  localparam int FracDen    = LevelMax * SectorSpan;   // 15300

  // s * offset term and 15300 - term: 0..15300
  localparam int TermW = 14;
  // v * (255 - s): 0..65025
  localparam int PnumW = 16;
  // v * (15300 - term): 0..3901500
  localparam int QnumW = 22;

  // Exact reciprocal multiply: floor(x / d) = (x * m) >> (n + l),
  // m = ceil(2^(n+l) / d), 2^l >= d, x < 2^n
  localparam int PShift = PnumW + 8;
  localparam int PRecW  = 17;
  localparam logic [PRecW-1:0] PRecip =
    PRecW'(((64'd1 << PShift) + 64'(LevelMax) - 64'd1) / 64'(LevelMax));

  localparam int QShift = QnumW + 14;
  localparam int QRecW  = 23;
  localparam logic [QRecW-1:0] QRecip =
    QRecW'(((64'd1 << QShift) + 64'(FracDen) - 64'd1) / 64'(FracDen));

  // 60-degree hue sectors
  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYN  = 3'd2,
    SEC_CYN_BLU  = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_t;

endpackage

@@ hw/rtl/hsv_to_rgb565_converter_core.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb565_converter_core
// Six-stage pipeline that turns a hue/saturation/value item into one packed
// RGB565 pixel word, using exact integer rationals and reciprocal multiplies.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  hsv      | input     | hsv_valid/hsv_stall  | hue_deg, sat_level, val_level
//  rgb      | output    | rgb_valid/rgb_stall  | rgb565_word
//
// One item enters per clock while hsv_stall is low; each result is valid once its
// item has passed all six stages, the last of them being the output register.
// The stages run in the chain hue reduce, sector split, products, numerators,
// reciprocal multiply, select and pack. rst clears the stage valid bits only.
// A stall on rgb while rgb_valid is high freezes the whole pipeline and raises
// hsv_stall; nothing is lost.
// ----------------------------------------------------------------------------
module hsv_to_rgb565_converter_core
  import hsvc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              hsv_valid,
  output logic              hsv_stall,
  input  logic [HueW-1:0]   hue_deg,
  input  logic [LevelW-1:0] sat_level,
  input  logic [LevelW-1:0] val_level,
  output logic              rgb_valid,
  input  logic              rgb_stall,
  output logic [PixW-1:0]   rgb565_word
);

  // Pipeline advance: hold everything while the output item is stalled
  logic adv;
  assign adv       = !(rgb_valid && rgb_stall);
  assign hsv_stall = !adv;

  // Stage valid bits
  logic vld1, vld2, vld3, vld4, vld5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      vld3      <= 1'b0;
      vld4      <= 1'b0;
      vld5      <= 1'b0;
      rgb_valid <= 1'b0;
    end else if (adv) begin
      vld1      <= hsv_valid;
      vld2      <= vld1;
      vld3      <= vld2;
      vld4      <= vld3;
      vld5      <= vld4;
      rgb_valid <= vld5;
    end
  end

  // ---------------- Stage 1: reduce hue modulo 360 ----------------
  logic [HmodW-1:0]  s1_hue;
  logic [LevelW-1:0] s1_sat, s1_val;
  logic [HmodW-1:0]  hue_mod_next;

  always_comb begin
    priority if (hue_deg >= HueW'(2 * FullCircle)) begin
      hue_mod_next = HmodW'(hue_deg - HueW'(2 * FullCircle));
    end else if (hue_deg >= HueW'(FullCircle)) begin
      hue_mod_next = HmodW'(hue_deg - HueW'(FullCircle));
    end else begin
      hue_mod_next = HmodW'(hue_deg);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_hue <= hue_mod_next;
      s1_sat <= sat_level;
      s1_val <= val_level;
    end
  end

  // ---------------- Stage 2: sector split, p numerator ----------------
  sector_t           s2_sec;
  logic [OffW-1:0]   s2_off;
  logic [LevelW-1:0] s2_sat, s2_val;
  logic [PnumW-1:0]  s2_pnum;
  sector_t           sec_next;
  logic [HmodW-1:0]  base_next;

  always_comb begin
    priority if (s1_hue < HmodW'(SectorSpan)) begin
      sec_next  = SEC_RED_YEL;
      base_next = HmodW'(0);
    end else if (s1_hue < HmodW'(2 * SectorSpan)) begin
      sec_next  = SEC_YEL_GRN;
      base_next = HmodW'(SectorSpan);
    end else if (s1_hue < HmodW'(3 * SectorSpan)) begin
      sec_next  = SEC_GRN_CYN;
      base_next = HmodW'(2 * SectorSpan);
    end else if (s1_hue < HmodW'(4 * SectorSpan)) begin
      sec_next  = SEC_CYN_BLU;
      base_next = HmodW'(3 * SectorSpan);
    end else if (s1_hue < HmodW'(5 * SectorSpan)) begin
      sec_next  = SEC_BLU_MAG;
      base_next = HmodW'(4 * SectorSpan);
    end else begin
      sec_next  = SEC_MAG_RED;
      base_next = HmodW'(5 * SectorSpan);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sec  <= sec_next;
      s2_off  <= OffW'(s1_hue - base_next);
      s2_sat  <= s1_sat;
      s2_val  <= s1_val;
      s2_pnum <= PnumW'(s1_val) * PnumW'(LevelW'(LevelMax) - s1_sat);
    end
  end

  // ---------------- Stage 3: q/t terms, p reciprocal product ----------------
  sector_t                s3_sec;
  logic [LevelW-1:0]      s3_val;
  logic [TermW-1:0]       s3_qden, s3_tden;
  logic [PnumW+PRecW-1:0] s3_pprod;
  logic [OffW-1:0]        off_rem;
  logic [TermW-1:0]       q_term, t_term;

  always_comb begin
    off_rem = OffW'(SectorSpan) - s2_off;
    q_term  = TermW'(s2_sat) * TermW'(s2_off);
    t_term  = TermW'(s2_sat) * TermW'(off_rem);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sec   <= s2_sec;
      s3_val   <= s2_val;
      s3_qden  <= TermW'(FracDen) - q_term;
      s3_tden  <= TermW'(FracDen) - t_term;
      s3_pprod <= (PnumW+PRecW)'(s2_pnum) * (PnumW+PRecW)'(PRecip);
    end
  end

  // ---------------- Stage 4: q/t numerators, p quotient ----------------
  sector_t           s4_sec;
  logic [LevelW-1:0] s4_val, s4_p;
  logic [QnumW-1:0]  s4_qnum, s4_tnum;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_sec  <= s3_sec;
      s4_val  <= s3_val;
      s4_p    <= s3_pprod[PShift +: LevelW];
      s4_qnum <= QnumW'(s3_val) * QnumW'(s3_qden);
      s4_tnum <= QnumW'(s3_val) * QnumW'(s3_tden);
    end
  end

  // ---------------- Stage 5: q/t reciprocal products ----------------
  sector_t                s5_sec;
  logic [LevelW-1:0]      s5_val, s5_p;
  logic [QnumW+QRecW-1:0] s5_qprod, s5_tprod;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_sec   <= s4_sec;
      s5_val   <= s4_val;
      s5_p     <= s4_p;
      s5_qprod <= (QnumW+QRecW)'(s4_qnum) * (QnumW+QRecW)'(QRecip);
      s5_tprod <= (QnumW+QRecW)'(s4_tnum) * (QnumW+QRecW)'(QRecip);
    end
  end

  // ---------------- Stage 6: select channels, pack ----------------
  logic [LevelW-1:0] lvl_q, lvl_t;
  logic [LevelW-1:0] red, grn, blu;

  assign lvl_q = s5_qprod[QShift +: LevelW];
  assign lvl_t = s5_tprod[QShift +: LevelW];

  always_comb begin
    unique case (s5_sec)
      SEC_RED_YEL: begin red = s5_val; grn = lvl_t;  blu = s5_p;   end
      SEC_YEL_GRN: begin red = lvl_q;  grn = s5_val; blu = s5_p;   end
      SEC_GRN_CYN: begin red = s5_p;   grn = s5_val; blu = lvl_t;  end
      SEC_CYN_BLU: begin red = s5_p;   grn = lvl_q;  blu = s5_val; end
      SEC_BLU_MAG: begin red = lvl_t;  grn = s5_p;   blu = s5_val; end
      SEC_MAG_RED: begin red = s5_val; grn = s5_p;   blu = lvl_q;  end
      default:     begin red = s5_val; grn = s5_p;   blu = lvl_q;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rgb565_word <= {red[7:3], grn[7:2], blu[7:3]};
    end
  end

endmodule
